>>> sv/gafc_pkg.sv
// ----------------------------------------------------------------------------
// gafc_pkg
// Shared types and constants for the GET APDU frame checker.
// ----------------------------------------------------------------------------
package gafc_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 16;

	localparam logic [7:0] TAG_REQUEST  = 8'hC1;
	localparam logic [7:0] TAG_RESPONSE = 8'hC4;
	localparam logic [7:0] TAG_OCTETS   = 8'h09;
	localparam logic [7:0] TAG_UINT8    = 8'h11;
	localparam logic [7:0] TAG_ARRAY    = 8'h01;
	localparam logic [7:0] TAG_STRUCT   = 8'h02;
	localparam logic [7:0] CHOICE_BYTE  = 8'h00;

	localparam logic [7:0] MAX_RESULT   = 8'd3;
	localparam logic [2:0] POFF_BASE    = 3'd4;
	localparam logic [2:0] POFF_CHOICE  = 3'd5;

	localparam logic [2:0] OFF_KIND     = 3'd0;
	localparam logic [2:0] OFF_SUB      = 3'd1;
	localparam logic [2:0] OFF_INVOKE   = 3'd2;
	localparam logic [2:0] OFF_FOURTH   = 3'd3;
	localparam logic [2:0] OFF_CHOICE   = 3'd4;

	typedef enum logic [3:0] {
		ERR_NONE         = 4'd0,
		ERR_SHORT        = 4'd1,
		ERR_APDU         = 4'd2,
		ERR_SUBTYPE      = 4'd3,
		ERR_RESULT       = 4'd4,
		ERR_UINT8        = 4'd5,
		ERR_ARRAY_HDR    = 4'd6,
		ERR_ARRAY_ELEMS  = 4'd7,
		ERR_STRUCT_HDR   = 4'd8,
		ERR_STRUCT_ELEMS = 4'd9,
		ERR_TAG          = 4'd10
	} err_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
	} in_beat_t;

	typedef struct packed {
		logic        frame_ok;
		logic [3:0]  error_kind;
		logic [2:0]  error_position;
		logic        is_response_apdu;
		logic [7:0]  sub_kind;
		logic [3:0]  invoke_number;
		logic        high_priority;
		logic [7:0]  fourth_byte;
		logic        choice_seen;
		logic [7:0]  payload_kind;
		logic [2:0]  payload_start;
		logic [15:0] frame_bytes;
	} verdict_t;

endpackage

>>> sv/gafc_tracker.sv
// ----------------------------------------------------------------------------
// gafc_tracker
// Per-frame header state, error latch and verdict logic.
// ----------------------------------------------------------------------------
module gafc_tracker
	import gafc_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_beat_t beat,
	output verdict_t verdict
);

	localparam int unsigned LW = LENGTH_BITS;

	logic [LW-1:0] pos_q, pos_d;
	logic          resp_q, resp_d;
	logic          list_q, list_d;
	logic [7:0]    sub_q, sub_d;
	logic [7:0]    invoke_q, invoke_d;
	logic [7:0]    fourth_q, fourth_d;
	logic          choice_q, choice_d;
	logic [2:0]    poff_q, poff_d;
	logic [7:0]    tag_q, tag_d;
	logic [7:0]    count_q, count_d;
	err_kind_t     err_q, err_d;
	logic [2:0]    eoff_q, eoff_d;

	logic [7:0]    b;
	logic          sub_ok;
	err_kind_t     kind;
	logic [2:0]    kind_off;
	logic [LW-1:0] off_w, off2_w, cnt2_w;
	logic          has_payload;

	assign b = beat.data_byte;

	always_comb begin
		resp_d   = resp_q;
		list_d   = list_q;
		sub_d    = sub_q;
		invoke_d = invoke_q;
		fourth_d = fourth_q;
		choice_d = choice_q;
		poff_d   = poff_q;
		tag_d    = tag_q;
		count_d  = count_q;
		err_d    = err_q;
		eoff_d   = eoff_q;
		sub_ok   = 1'b1;

		if (pos_q == LW'(OFF_KIND)) begin
			if (b == TAG_REQUEST) begin
				resp_d = 1'b0;
			end else if (b == TAG_RESPONSE) begin
				resp_d = 1'b1;
			end else if (err_q == ERR_NONE) begin
				err_d  = ERR_APDU;
				eoff_d = OFF_KIND;
			end
		end else if (pos_q == LW'(OFF_SUB)) begin
			sub_d = b;
			if (err_q == ERR_NONE) begin
				if (resp_q) begin
					sub_ok = (b >= 8'd1) && (b <= 8'd4);
					list_d = (b == 8'd3) || (b == 8'd4);
				end else begin
					sub_ok = (b >= 8'd1) && (b <= 8'd3);
					list_d = (b == 8'd3);
				end
				if (!sub_ok) begin
					err_d  = ERR_SUBTYPE;
					eoff_d = OFF_SUB;
				end
			end
		end else if (pos_q == LW'(OFF_INVOKE)) begin
			invoke_d = b;
		end else if (pos_q == LW'(OFF_FOURTH)) begin
			fourth_d = b;
			if (err_q == ERR_NONE && !(resp_q && list_q) && b > MAX_RESULT) begin
				err_d  = ERR_RESULT;
				eoff_d = OFF_FOURTH;
			end
		end else if (pos_q == LW'(OFF_CHOICE)) begin
			if (resp_q && list_q && b == CHOICE_BYTE) begin
				choice_d = 1'b1;
				poff_d   = POFF_CHOICE;
			end
		end

		if (pos_q == LW'(poff_d)) begin
			tag_d = b;
		end else if (pos_q == LW'(poff_d) + LW'(1)) begin
			count_d = b;
		end

		pos_d = pos_q + LW'(pos_q != '1);
	end

	// verdict from the state as it stands after this beat
	assign off_w       = LW'(poff_d);
	assign off2_w      = off_w + LW'(2);
	assign cnt2_w      = LW'({count_d, 1'b0});
	assign has_payload = pos_d > off_w;

	always_comb begin
		kind     = ERR_NONE;
		kind_off = 3'd0;
		priority if (pos_d < LW'(4)) begin
			kind = ERR_SHORT;
		end else if (err_d != ERR_NONE) begin
			kind     = err_d;
			kind_off = eoff_d;
		end else if (has_payload) begin
			priority if (tag_d == TAG_OCTETS) begin
				kind = ERR_NONE;
			end else if (tag_d == TAG_UINT8) begin
				if (pos_d < off2_w) begin
					kind     = ERR_UINT8;
					kind_off = poff_d;
				end
			end else if (tag_d == TAG_ARRAY || tag_d == TAG_STRUCT) begin
				if (pos_d < off2_w) begin
					kind     = (tag_d == TAG_ARRAY) ? ERR_ARRAY_HDR : ERR_STRUCT_HDR;
					kind_off = poff_d;
				end else if (pos_d - off2_w < cnt2_w) begin
					kind     = (tag_d == TAG_ARRAY) ? ERR_ARRAY_ELEMS : ERR_STRUCT_ELEMS;
					kind_off = poff_d + 3'd1;
				end
			end else begin
				kind     = ERR_TAG;
				kind_off = poff_d;
			end
		end else begin
			kind     = ERR_NONE;
			kind_off = 3'd0;
		end
	end

	always_comb begin
		verdict.frame_ok         = (kind == ERR_NONE);
		verdict.error_kind       = kind;
		verdict.error_position   = kind_off;
		verdict.is_response_apdu = resp_d;
		verdict.sub_kind         = sub_d;
		verdict.invoke_number    = invoke_d[3:0];
		verdict.high_priority    = invoke_d[7];
		verdict.fourth_byte      = fourth_d;
		verdict.choice_seen      = choice_d;
		verdict.payload_kind     = has_payload ? tag_d : 8'd0;
		verdict.payload_start    = poff_d;
		verdict.frame_bytes      = (32'(pos_d) > 32'hFFFF) ? 16'hFFFF : 16'(pos_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			resp_q   <= 1'b0;
			list_q   <= 1'b0;
			sub_q    <= '0;
			invoke_q <= '0;
			fourth_q <= '0;
			choice_q <= 1'b0;
			poff_q   <= POFF_BASE;
			tag_q    <= '0;
			count_q  <= '0;
			err_q    <= ERR_NONE;
			eoff_q   <= '0;
		end else if (step && beat.end_of_frame) begin
			pos_q    <= '0;
			resp_q   <= 1'b0;
			list_q   <= 1'b0;
			sub_q    <= '0;
			invoke_q <= '0;
			fourth_q <= '0;
			choice_q <= 1'b0;
			poff_q   <= POFF_BASE;
			tag_q    <= '0;
			count_q  <= '0;
			err_q    <= ERR_NONE;
			eoff_q   <= '0;
		end else if (step) begin
			pos_q    <= pos_d;
			resp_q   <= resp_d;
			list_q   <= list_d;
			sub_q    <= sub_d;
			invoke_q <= invoke_d;
			fourth_q <= fourth_d;
			choice_q <= choice_d;
			poff_q   <= poff_d;
			tag_q    <= tag_d;
			count_q  <= count_d;
			err_q    <= err_d;
			eoff_q   <= eoff_d;
		end
	end

endmodule

>>> sv/get_apdu_frame_checker.sv
// The verdict is valid in the cycle after the last byte of a frame is taken.
// Throughput: one byte per cycle; the per-byte state update is registered.
// A pending verdict that is not taken stalls byte intake only while it waits.
// Reset: arst_n clears the frame state and drops verdict_valid at once.
// ----------------------------------------------------------------------------
// get_apdu_frame_checker
// Byte-wise GET APDU header check with one verdict beat per frame.
// ----------------------------------------------------------------------------
module get_apdu_frame_checker
	import gafc_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_ready,
	input  in_beat_t byte_data,
	output logic     verdict_valid,
	input  logic     verdict_ready,
	output verdict_t verdict
);

	logic     accept;
	logic     verdict_valid_q;
	verdict_t verdict_q;
	verdict_t verdict_c;

	assign byte_ready    = !verdict_valid_q || verdict_ready;
	assign accept        = byte_valid && byte_ready;
	assign verdict_valid = verdict_valid_q;
	assign verdict       = verdict_q;

	gafc_tracker #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.beat    (byte_data),
		.verdict (verdict_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (accept && byte_data.end_of_frame) begin
			verdict_valid_q <= 1'b1;
		end else if (verdict_ready) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && byte_data.end_of_frame) begin
			verdict_q <= verdict_c;
		end
	end

	a_eof_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		accept && byte_data.end_of_frame |=> verdict_valid)
		else $error("no verdict after last byte");

	a_stall_blocks_intake: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && !verdict_ready |-> !byte_ready)
		else $error("byte taken while verdict stalled");

	a_ok_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (verdict.frame_ok == (verdict.error_kind == ERR_NONE)))
		else $error("frame_ok inconsistent with error_kind");

	a_payload_start: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (verdict.payload_start == POFF_BASE ||
			verdict.payload_start == POFF_CHOICE))
		else $error("bad payload_start");

	a_short_frame: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && verdict.error_kind == ERR_SHORT |->
			verdict.frame_bytes < 16'd4 && verdict.error_position == 3'd0)
		else $error("short-frame verdict inconsistent");

endmodule
